// ----- rtl/mjsc_pkg.sv -----
package mjsc_pkg;

    // Field widths of the sensor reading and of the conditioned result.
    localparam int unsigned AXIS_W      = 12;
    localparam int unsigned DELTA_W     = 13;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 1;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_TUSER_W = 2;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned LIMIT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HYSTERESIS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DEADZONE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT      = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_PRESS_THRESHOLD  = 12'd50;
    localparam logic [CFG_DATA_W-1:0] RST_PRESS_HYSTERESIS = 12'd10;
    localparam logic [CFG_DATA_W-1:0] RST_MOVE_DEADZONE    = 12'd3;
    localparam logic [LIMIT_W-1:0]    RST_ERROR_LIMIT      = 8'd5;

    // Both diagnostic bits must be set for the reading to be trusted.
    localparam logic [BYTE_W-1:0] DIAG_OK_MASK = 8'h0C;

    localparam logic [LIMIT_W-1:0] ERROR_RUN_MAX = 8'd255;

    typedef enum logic [OUT_TUSER_W-1:0] {
        STAT_CALIBRATING = 2'd0,
        STAT_TRACKING    = 2'd1,
        STAT_BAD         = 2'd2,
        STAT_REINIT      = 2'd3
    } status_t;

endpackage

// ----- rtl/magnetic_joystick_sample_conditioner_core.sv -----
// Magnetic joystick sample conditioner.
// Input items arrive on the s_ stream: one polled sensor reading each, the six register
// bytes in s_tdata and the bus-ok flag in s_tuser. Every accepted item gives exactly one
// result item on the m_ stream: the status code in m_tuser, and the X/Y deltas and the
// move, press and press-change flags in m_tdata. The four tuning registers are written
// through the cfg_ channel, which is always ready; write them only while the block is idle.
// An item is captured in an input register, conditioned by combinational logic and held in
// a result register, so m_tvalid rises once the item has passed from the input register into
// the result register; one item can be taken every cycle while the receiver keeps m_tready high.
// The one exception is the end of calibration: the reading that completes the average
// starts a division of the sums by CAL_SAMPLES (a reciprocal multiplication per
// axis), and during the division the next item waits in the input register.
// A stalled receiver (m_tready low) holds the result register; the input register then
// fills, and s_tready falls once both stages hold an item.
// Reset clears the calibration sums, the origins, the press state and the error count, loads
// the register defaults (threshold 50, hysteresis 10, deadzone 3, error limit 5) and
// empties both stages; calibration then starts afresh with the next valid readings.
module magnetic_joystick_sample_conditioner_core #(
    parameter int unsigned CAL_SAMPLES = 100
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata from bit 0: x_high, y_high, z_high, xy_low, z_low, diag.
    input  logic [mjsc_pkg::IN_TDATA_W-1:0]        s_tdata,
    // s_tuser from bit 0: read_ok.
    input  logic [mjsc_pkg::IN_TUSER_W-1:0]        s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata from bit 0: delta_x, delta_y, moved, pressed, press_changed, three zero bits.
    output logic [mjsc_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // m_tuser from bit 0: status.
    output logic [mjsc_pkg::OUT_TUSER_W-1:0]       m_tuser,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mjsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mjsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import mjsc_pkg::*;

    // The calibration sum must hold CAL_SAMPLES readings of the full 12-bit range.
    localparam int unsigned CAL_L  = $clog2(CAL_SAMPLES);
    localparam int unsigned SUM_W  = AXIS_W + CAL_L;
    localparam int unsigned CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned MAG_W  = SUM_W;
    // Rounded-up reciprocal: exact floor division for every magnitude below 2^MAG_W.
    localparam int unsigned SHIFT  = MAG_W + CAL_L;
    localparam int unsigned RCP_W  = MAG_W + 2;
    localparam int unsigned PROD_W = MAG_W + RCP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RCP_W-1:0] RECIP     = RCP_W'(RECIP_VAL);
    localparam logic [CNT_W-1:0] CAL_COUNT = CNT_W'(CAL_SAMPLES);

    // Signed division by CAL_SAMPLES, truncating towards zero.
    function automatic logic signed [AXIS_W-1:0] cal_origin(
        input logic signed [SUM_W-1:0] sum
    );
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [AXIS_W-1:0] quo;
        neg  = sum[SUM_W-1];
        mag  = neg ? MAG_W'(-sum) : MAG_W'(sum);
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        quo  = prod[SHIFT +: AXIS_W];
        return neg ? $signed(-quo) : $signed(quo);
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0] press_threshold_reg;
    logic [CFG_DATA_W-1:0] press_hysteresis_reg;
    logic [CFG_DATA_W-1:0] move_deadzone_reg;
    logic [LIMIT_W-1:0]    error_limit_reg;

    // Input stage.
    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  in_ok_reg;

    // Conditioning state.
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [AXIS_W-1:0] home_x_reg, home_y_reg, home_z_reg;
    logic                     cal_done_reg, cal_done_next;
    logic                     div_pend_reg, div_pend_next;
    logic                     press_reg, press_next;
    logic [LIMIT_W-1:0]       error_run_reg, error_run_next;

    // Result stage.
    logic                      out_valid_reg;
    status_t                   status_reg, status_next;
    logic signed [DELTA_W-1:0] dx_reg, dx_next;
    logic signed [DELTA_W-1:0] dy_reg, dy_next;
    logic                      moved_reg, moved_next;
    logic                      pressed_reg;
    logic                      changed_reg, changed_next;

    logic move;

    // Item moves from the input register into the result register.
    assign move      = in_valid_reg && !div_pend_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || move;
    assign cfg_ready = 1'b1;

    // Unpacking of the held reading.
    logic [BYTE_W-1:0]        x_high, y_high, z_high, xy_low, z_low, diag;
    logic                     good;
    logic signed [AXIS_W-1:0] x_s, y_s, z_s;

    assign x_high = in_data_reg[0*BYTE_W +: BYTE_W];
    assign y_high = in_data_reg[1*BYTE_W +: BYTE_W];
    assign z_high = in_data_reg[2*BYTE_W +: BYTE_W];
    assign xy_low = in_data_reg[3*BYTE_W +: BYTE_W];
    assign z_low  = in_data_reg[4*BYTE_W +: BYTE_W];
    assign diag   = in_data_reg[5*BYTE_W +: BYTE_W];
    assign good   = in_ok_reg && ((diag & DIAG_OK_MASK) == DIAG_OK_MASK);
    assign x_s    = $signed({x_high, xy_low[7:4]});
    assign y_s    = $signed({y_high, xy_low[3:0]});
    assign z_s    = $signed({z_high, z_low[3:0]});

    // Tracking arithmetic: deltas from the origins and their magnitudes.
    logic signed [DELTA_W-1:0] dx_w, dy_w, dz_w, rel_w;
    logic [DELTA_W-1:0]        adx, ady, adz;
    logic [DELTA_W-1:0]        thr_w, dz_lim;

    assign dx_w   = DELTA_W'(x_s) - DELTA_W'(home_x_reg);
    assign dy_w   = DELTA_W'(y_s) - DELTA_W'(home_y_reg);
    assign dz_w   = DELTA_W'(z_s) - DELTA_W'(home_z_reg);
    assign adx    = dx_w[DELTA_W-1] ? DELTA_W'(-dx_w) : DELTA_W'(dx_w);
    assign ady    = dy_w[DELTA_W-1] ? DELTA_W'(-dy_w) : DELTA_W'(dy_w);
    assign adz    = dz_w[DELTA_W-1] ? DELTA_W'(-dz_w) : DELTA_W'(dz_w);
    assign thr_w  = DELTA_W'(press_threshold_reg);
    assign dz_lim = DELTA_W'(move_deadzone_reg);
    // The release level goes negative when the hysteresis exceeds the threshold.
    assign rel_w  = $signed(thr_w) - $signed(DELTA_W'(press_hysteresis_reg));

    always_comb
    begin
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_z_next     = sum_z_reg;
        count_next     = count_reg;
        cal_done_next  = cal_done_reg;
        div_pend_next  = 1'b0;
        press_next     = press_reg;
        error_run_next = error_run_reg;
        status_next    = STAT_CALIBRATING;
        dx_next        = '0;
        dy_next        = '0;
        moved_next     = 1'b0;
        changed_next   = 1'b0;
        if (move)
        begin
            if (!good)
            begin
                if (error_run_reg != ERROR_RUN_MAX)
                begin
                    error_run_next = error_run_reg + 1'b1;
                end
                // A bad reading during calibration restarts the average.
                if (!cal_done_reg)
                begin
                    sum_x_next = '0;
                    sum_y_next = '0;
                    sum_z_next = '0;
                    count_next = '0;
                end
                status_next = (error_run_next > error_limit_reg) ? STAT_REINIT : STAT_BAD;
            end
            else
            begin
                error_run_next = '0;
                if (!cal_done_reg)
                begin
                    sum_x_next = sum_x_reg + SUM_W'(x_s);
                    sum_y_next = sum_y_reg + SUM_W'(y_s);
                    sum_z_next = sum_z_reg + SUM_W'(z_s);
                    count_next = count_reg + 1'b1;
                    if (count_next == CAL_COUNT)
                    begin
                        cal_done_next = 1'b1;
                        div_pend_next = 1'b1;
                    end
                    status_next = STAT_CALIBRATING;
                end
                else
                begin
                    if (!press_reg && (adz > thr_w))
                    begin
                        press_next = 1'b1;
                    end
                    else if (press_reg && ($signed(adz) < rel_w))
                    begin
                        press_next = 1'b0;
                    end
                    changed_next = press_next ^ press_reg;
                    moved_next   = (adx > dz_lim) || (ady > dz_lim);
                    dx_next      = dx_w;
                    dy_next      = dy_w;
                    status_next  = STAT_TRACKING;
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_threshold_reg  <= RST_PRESS_THRESHOLD;
            press_hysteresis_reg <= RST_PRESS_HYSTERESIS;
            move_deadzone_reg    <= RST_MOVE_DEADZONE;
            error_limit_reg      <= RST_ERROR_LIMIT;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            sum_x_reg            <= '0;
            sum_y_reg            <= '0;
            sum_z_reg            <= '0;
            count_reg            <= '0;
            home_x_reg           <= '0;
            home_y_reg           <= '0;
            home_z_reg           <= '0;
            cal_done_reg         <= 1'b0;
            div_pend_reg         <= 1'b0;
            press_reg            <= 1'b0;
            error_run_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESS_THRESHOLD:  press_threshold_reg  <= cfg_data;
                    CFG_PRESS_HYSTERESIS: press_hysteresis_reg <= cfg_data;
                    CFG_MOVE_DEADZONE:    move_deadzone_reg    <= cfg_data;
                    CFG_ERROR_LIMIT:      error_limit_reg      <= cfg_data[LIMIT_W-1:0];
                    default:              ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_z_reg     <= sum_z_next;
            count_reg     <= count_next;
            cal_done_reg  <= cal_done_next;
            div_pend_reg  <= div_pend_next;
            press_reg     <= press_next;
            error_run_reg <= error_run_next;
            // The origins are taken from the completed sums in the cycle after the last
            // calibration reading; no item advances in that cycle.
            if (div_pend_reg)
            begin
                home_x_reg <= cal_origin(sum_x_reg);
                home_y_reg <= cal_origin(sum_y_reg);
                home_z_reg <= cal_origin(sum_z_reg);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_ok_reg   <= s_tuser[0];
        end
        if (move)
        begin
            status_reg  <= status_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            moved_reg   <= moved_next;
            pressed_reg <= press_next;
            changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, changed_reg, pressed_reg, moved_reg, dy_reg, dx_reg};

`ifndef SYNTHESIS
    // A tracking result is only ever produced once the origins have settled.
    a_track_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (move && status_next == STAT_TRACKING) |-> (cal_done_reg && !div_pend_reg))
        else $error("tracking result produced before the origins were loaded");

    // Results other than tracking carry no deltas and no movement or change marks.
    a_quiet_untracked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STAT_TRACKING) |->
        (dx_reg == '0 && dy_reg == '0 && !moved_reg && !changed_reg))
        else $error("non-tracking result carries tracking fields");

    // No item moves while the division of the sums is pending, and the flag is clear in the next cycle.
    a_single_div_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        div_pend_reg |-> (!move ##1 !div_pend_reg))
        else $error("origin division did not complete in one cycle");

    // The calibration count never runs past the number of samples averaged.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAL_COUNT)
        else $error("calibration sample count overran");

    // Sample count moves only while calibrating.
    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_done_reg && !div_pend_reg) |=> $stable(count_reg))
        else $error("sample count changed after calibration");
`endif

endmodule

// ----- tb/mjsc_conditioning_monitor.sv -----
module mjsc_conditioning_monitor #(
    parameter int unsigned CAL_SAMPLES = 100
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mjsc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [mjsc_pkg::IN_TUSER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mjsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [mjsc_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mjsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mjsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               pending,
    output int                               mismatches,
    output int                               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mjsc_pkg::*;

    typedef struct packed {
        status_t                   status;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      moved;
        logic                      pressed;
        logic                      press_changed;
    } conditioned_t;

    // Conditioned readings still to come out of the block, oldest first.
    conditioned_t conditioned_q[$];

    // Tuning registers as last written.
    logic [CFG_DATA_W-1:0]    press_threshold;
    logic [CFG_DATA_W-1:0]    press_hysteresis;
    logic [CFG_DATA_W-1:0]    move_deadzone;
    logic [LIMIT_W-1:0]       error_limit;

    // Calibration and tracking state.
    logic signed [19:0]       sum_x, sum_y, sum_z;
    logic [8:0]               sample_count;
    logic signed [AXIS_W-1:0] home_x, home_y, home_z;
    logic                     calibrated;
    logic                     press_state;
    logic [LIMIT_W-1:0]       error_run;

    function automatic conditioned_t condition_reading(input logic [IN_TDATA_W-1:0] reading,
                                                       input logic read_ok);
        logic [BYTE_W-1:0]        x_high, y_high, z_high, xy_low, z_low, diag;
        logic signed [AXIS_W-1:0] x, y, z;
        int                       adz, release_level, dx, dy;
        logic                     was_pressed;
        conditioned_t             r;
        {diag, z_low, xy_low, z_high, y_high, x_high} = reading;
        r = '0;
        if (!read_ok || (diag & DIAG_OK_MASK) != DIAG_OK_MASK) begin
            if (error_run != ERROR_RUN_MAX)
                error_run = error_run + 1'b1;
            // A bad reading during calibration throws the partial average away.
            if (!calibrated) begin
                sum_x = '0;
                sum_y = '0;
                sum_z = '0;
                sample_count = '0;
            end
            r.status = (error_run > error_limit) ? STAT_REINIT : STAT_BAD;
        end
        else begin
            x = {x_high, xy_low[7:4]};
            y = {y_high, xy_low[3:0]};
            z = {z_high, z_low[3:0]};
            error_run = '0;
            if (!calibrated) begin
                sum_x = sum_x + 20'(x);
                sum_y = sum_y + 20'(y);
                sum_z = sum_z + 20'(z);
                sample_count = sample_count + 1'b1;
                // Signed division truncates towards zero, as the block must.
                if (sample_count >= CAL_SAMPLES) begin
                    home_x = AXIS_W'(sum_x / int'(CAL_SAMPLES));
                    home_y = AXIS_W'(sum_y / int'(CAL_SAMPLES));
                    home_z = AXIS_W'(sum_z / int'(CAL_SAMPLES));
                    calibrated = 1'b1;
                end
                r.status = STAT_CALIBRATING;
            end
            else begin
                adz = int'(z) - int'(home_z);
                if (adz < 0)
                    adz = -adz;
                // A threshold below the hysteresis gives a negative release level.
                release_level = int'(press_threshold) - int'(press_hysteresis);
                was_pressed = press_state;
                if (!press_state && adz > int'(press_threshold))
                    press_state = 1'b1;
                else if (press_state && adz < release_level)
                    press_state = 1'b0;
                dx = int'(x) - int'(home_x);
                dy = int'(y) - int'(home_y);
                r.status = STAT_TRACKING;
                r.delta_x = dx[DELTA_W-1:0];
                r.delta_y = dy[DELTA_W-1:0];
                r.moved = ((dx < 0 ? -dx : dx) > int'(move_deadzone)) ||
                          ((dy < 0 ? -dy : dy) > int'(move_deadzone));
                r.press_changed = (press_state != was_pressed);
            end
        end
        r.pressed = press_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        conditioned_t seen;
        conditioned_t want;
        if (!rst_n) begin
            conditioned_q.delete();
            press_threshold  = RST_PRESS_THRESHOLD;
            press_hysteresis = RST_PRESS_HYSTERESIS;
            move_deadzone    = RST_MOVE_DEADZONE;
            error_limit      = RST_ERROR_LIMIT;
            sum_x = '0;
            sum_y = '0;
            sum_z = '0;
            sample_count = '0;
            home_x = '0;
            home_y = '0;
            home_z = '0;
            calibrated = 1'b0;
            press_state = 1'b0;
            error_run = '0;
            pending = 0;
            mismatches = 0;
            results_seen = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PRESS_THRESHOLD:  press_threshold  = cfg_data;
                    CFG_PRESS_HYSTERESIS: press_hysteresis = cfg_data;
                    CFG_MOVE_DEADZONE:    move_deadzone    = cfg_data;
                    CFG_ERROR_LIMIT:      error_limit      = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen.status        = status_t'(m_tuser);
                seen.delta_x       = m_tdata[DELTA_W-1:0];
                seen.delta_y       = m_tdata[2*DELTA_W-1:DELTA_W];
                seen.moved         = m_tdata[2*DELTA_W];
                seen.pressed       = m_tdata[2*DELTA_W+1];
                seen.press_changed = m_tdata[2*DELTA_W+2];
                results_seen++;
                if (conditioned_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with none outstanding: status %0d",
                                 $realtime, m_tuser);
                end
                else begin
                    want = conditioned_q.pop_front();
                    if (seen.status != want.status || seen.delta_x != want.delta_x ||
                        seen.delta_y != want.delta_y || seen.moved != want.moved ||
                        seen.pressed != want.pressed ||
                        seen.press_changed != want.press_changed ||
                        m_tdata[OUT_TDATA_W-1:2*DELTA_W+3] != '0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  expected status %0d dx %0d dy %0d mv %0b pr %0b ch %0b",
                                     want.status, want.delta_x, want.delta_y, want.moved,
                                     want.pressed, want.press_changed);
                            $display("  actual   status %0d dx %0d dy %0d mv %0b pr %0b ch %0b",
                                     seen.status, seen.delta_x, seen.delta_y, seen.moved,
                                     seen.pressed, seen.press_changed);
                            $display("  actual   padding %0h",
                                     m_tdata[OUT_TDATA_W-1:2*DELTA_W+3]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                conditioned_q.push_back(condition_reading(s_tdata, s_tuser[0]));
            pending = conditioned_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mjsc_pkg::*;

    localparam int unsigned CAL_SAMPLES = 100;
    localparam int          PERIOD      = 20;
    // Far beyond the slowest correct run.
    localparam int          RUN_LIMIT   = 4_000_000;
    // Item counts at which the idling pattern changes.
    localparam int          SWAP_AT     = 320;
    localparam int          STEADY_AT   = 640;
    localparam int          RANDOM_PER_SETTING = 60;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int pending;
    int failures;
    int results_seen;

    // Idling, in percent of cycles, for each side.
    int send_idle_pct = 34;
    int recv_idle_pct = 73;
    int items_sent    = 0;

    // Current tuning values and the origins that the calibration run should produce.
    int threshold, hysteresis, deadzone, limit;
    int home_x, home_y, home_z;

    always #(PERIOD / 2) clk = ~clk;

    magnetic_joystick_sample_conditioner_core #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    mjsc_conditioning_monitor #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pending     (pending),
        .mismatches  (failures),
        .results_seen(results_seen)
    );

    // The receiver stalls at random; the rate follows the current idling pattern.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Offers one reading and returns at the falling edge after it has been taken.
    // It must be called at a falling edge. The idling pattern is chosen from the
    // number of items sent so far: receiver lazy first, then sender lazy, then neither.
    task automatic send_reading(input logic [7:0] x_high, y_high, z_high, xy_low, z_low,
                                input logic [7:0] diag, input logic read_ok);
        send_idle_pct = (items_sent < SWAP_AT) ? 34 : (items_sent < STEADY_AT) ? 73 : 0;
        recv_idle_pct = (items_sent < SWAP_AT) ? 73 : (items_sent < STEADY_AT) ? 34 : 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {diag, z_low, xy_low, z_high, y_high, x_high};
        s_tuser  <= read_ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Packs three axis values into the sensor's register bytes. Only the low twelve
    // bits of each value are kept, and the unused upper nibble of z_low is random.
    task automatic send_axes(input int x, y, z, input logic [7:0] diag, input logic read_ok);
        logic [11:0] xv, yv, zv;
        logic [3:0]  junk;
        xv = x[11:0];
        yv = y[11:0];
        zv = z[11:0];
        junk = 4'($urandom);
        send_reading(xv[11:4], yv[11:4], zv[11:4], {xv[3:0], yv[3:0]}, {junk, zv[3:0]},
                     diag, read_ok);
    endtask

    function automatic logic [7:0] good_diag();
        return 8'($urandom) | DIAG_OK_MASK;
    endfunction

    // A reading that the block must reject: either the bus read failed or one or
    // both diagnostic bits are clear. The register bytes are random.
    task automatic send_bad_reading();
        logic [7:0] diag;
        logic       read_ok;
        diag = 8'($urandom);
        read_ok = 1'($urandom);
        if (read_ok) begin
            case ($urandom_range(0, 2))
                0:       diag[2] = 1'b0;
                1:       diag[3] = 1'b0;
                default: diag[3:2] = 2'b00;
            endcase
        end
        send_reading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     diag, read_ok);
    endtask

    // Lowers s_tvalid and waits until every result of the items sent has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Writes all four tuning registers back to back. Called only while idle.
    // The error limit is written with random bits above its eight-bit width.
    task automatic program_settings(input int thr, hyst, dz, lim);
        logic [CFG_DATA_W-1:0] values[4];
        logic [CFG_IDX_W-1:0]  index[4];
        logic [3:0]            junk;
        junk = 4'($urandom);
        index  = '{CFG_PRESS_THRESHOLD, CFG_PRESS_HYSTERESIS, CFG_MOVE_DEADZONE,
                   CFG_ERROR_LIMIT};
        values = '{thr[11:0], hyst[11:0], dz[11:0], {junk, lim[7:0]}};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= index[i];
            cfg_data  <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        threshold  = thr;
        hysteresis = hyst;
        deadzone   = dz;
        limit      = lim;
    endtask

    // One random item while tracking. Most are good readings placed around the
    // press threshold, the release level and the deadzone edge; the rest are bad
    // readings, bursts of bad readings that can raise the re-initialisation request
    // when the error limit is low, and wholly random bytes.
    task automatic send_tracking_item();
        int pick, span, zdev, x_off, y_off, burst;
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            span = deadzone + 8;
            x_off = int'($urandom_range(0, 2 * span)) - span;
            y_off = int'($urandom_range(0, 2 * span)) - span;
            case ($urandom_range(0, 2))
                0:       zdev = threshold + int'($urandom_range(0, 8)) - 4;
                1:       zdev = threshold - hysteresis + int'($urandom_range(0, 8)) - 4;
                default: zdev = int'($urandom_range(0, threshold + hysteresis + 16));
            endcase
            if ($urandom_range(0, 1))
                zdev = -zdev;
            send_axes(home_x + x_off, home_y + y_off, home_z + zdev, good_diag(), 1'b1);
        end
        else if (pick < 83) begin
            burst = $urandom_range(1, (limit + 3 < 24) ? limit + 3 : 24);
            repeat (burst)
                send_bad_reading();
        end
        else if (pick < 90) begin
            send_bad_reading();
        end
        else begin
            send_reading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int centre_x, centre_y, centre_z, nx, ny, nz, false_start;
        int cal_x, cal_y, cal_z;
        int settings[6][4];

        threshold  = int'(RST_PRESS_THRESHOLD);
        hysteresis = int'(RST_PRESS_HYSTERESIS);
        deadzone   = int'(RST_MOVE_DEADZONE);
        limit      = int'(RST_ERROR_LIMIT);
        // The Y centre is negative so that the average of its sum truncates
        // towards zero on the negative side.
        centre_x = int'($urandom_range(0, 600)) - 300;
        centre_y = -int'($urandom_range(50, 300));
        centre_z = $urandom_range(50, 300);

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        // Rejected readings before any calibration: failed bus read, and each of
        // the two diagnostic bits missing on its own.
        send_reading(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, DIAG_OK_MASK, 1'b0);
        send_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF7, 1'b1);
        send_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 1'b1);

        // A short start of calibration that a bad reading throws away, then a run
        // of bad readings past the default limit so the request shows while
        // still calibrating.
        repeat (3)
            send_axes(centre_x, centre_y, centre_z, good_diag(), 1'b1);
        send_axes(centre_x, centre_y, centre_z, DIAG_OK_MASK, 1'b0);
        repeat (7)
            send_bad_reading();

        // Two more false starts of random length before the clean calibration run.
        repeat (2) begin
            false_start = $urandom_range(10, 60);
            repeat (false_start)
                send_axes(centre_x + int'($urandom_range(0, 80)) - 40,
                          centre_y + int'($urandom_range(0, 80)) - 40,
                          centre_z + int'($urandom_range(0, 80)) - 40, good_diag(), 1'b1);
            send_bad_reading();
        end

        // The clean run; its sums give the origins used to aim the later items.
        cal_x = 0;
        cal_y = 0;
        cal_z = 0;
        repeat (CAL_SAMPLES) begin
            nx = centre_x + int'($urandom_range(0, 80)) - 40;
            ny = centre_y + int'($urandom_range(0, 80)) - 40;
            nz = centre_z + int'($urandom_range(0, 80)) - 40;
            cal_x += nx;
            cal_y += ny;
            cal_z += nz;
            send_axes(nx, ny, nz, good_diag(), 1'b1);
        end
        home_x = cal_x / int'(CAL_SAMPLES);
        home_y = cal_y / int'(CAL_SAMPLES);
        home_z = cal_z / int'(CAL_SAMPLES);

        // Register settings per phase: threshold, hysteresis, deadzone, error limit.
        // The defaults, the lowest and highest values, a threshold below the
        // hysteresis so the stick never releases, and two random sets, the first
        // of which carries the saturating error burst.
        settings[0] = '{50, 10, 3, 5};
        settings[1] = '{0, 0, 0, 0};
        settings[2] = '{4095, 4095, 4095, 255};
        settings[3] = '{20, 40, 10, 2};
        settings[4] = '{$urandom_range(30, 300), 0, $urandom_range(0, 60), 254};
        settings[4][1] = $urandom_range(0, settings[4][0]);
        settings[5] = '{$urandom_range(100, 2000), $urandom_range(0, 4095),
                        $urandom_range(0, 400), $urandom_range(0, 255)};

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            program_settings(settings[phase][0], settings[phase][1], settings[phase][2],
                             settings[phase][3]);

            if (phase == 0) begin
                // Extreme register bytes: all clear, all set, and the largest
                // positive and negative axis values.
                send_reading(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, DIAG_OK_MASK, 1'b1);
                send_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
                send_reading(8'h7F, 8'h80, 8'h7F, 8'hF0, 8'h0F, 8'h0C, 1'b1);
                send_reading(8'h80, 8'h7F, 8'h80, 8'h0F, 8'hF0, 8'hFF, 1'b1);

                // Press with hysteresis: centre releases, one above the threshold
                // presses, the threshold and the release level themselves hold,
                // a bad reading keeps the press, one below the release level lets
                // go, and the negative side presses too.
                send_axes(home_x, home_y, home_z, DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z + threshold + 1, DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z + threshold, DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z - (threshold - hysteresis),
                          DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z, DIAG_OK_MASK, 1'b0);
                send_axes(home_x, home_y, home_z + threshold - hysteresis - 1,
                          DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z - threshold - 1, DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y, home_z, DIAG_OK_MASK, 1'b1);

                // Deadzone edge on both axes.
                send_axes(home_x + deadzone, home_y - deadzone, home_z, DIAG_OK_MASK, 1'b1);
                send_axes(home_x + deadzone + 1, home_y, home_z, DIAG_OK_MASK, 1'b1);
                send_axes(home_x, home_y - deadzone - 1, home_z, DIAG_OK_MASK, 1'b1);
            end

            // Long enough for the error count to reach its ceiling and stay there.
            if (phase == 4)
                repeat (260)
                    send_bad_reading();

            repeat (RANDOM_PER_SETTING)
                send_tracking_item();
        end

        wait_idle();
        repeat (4)
            @(negedge clk);

        $display("Sent %0d readings through calibration restarts and six register settings,",
                 items_sent);
        $display("including a saturating error burst; %0d result items were checked.",
                 results_seen);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Run stopped by timeout with %0d results outstanding.", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
